// ----- sv/acc_pkg.sv -----
// Shared types, widths and constants for the box/circle contact pipeline.
// No dependencies; every other file refers to this package by scoped names.
package acc_pkg;

   localparam int COORD_WIDTH      = 32;
   localparam int NORMAL_FRAC_BITS = 14;
   localparam int NORMAL_W         = 16;
   localparam int RADIUS_W         = COORD_WIDTH - 1;
   localparam int OFF_W            = COORD_WIDTH + 1;
   localparam int VEC_W            = COORD_WIDTH + 2;
   localparam int DIN_W            = VEC_W;
   localparam int SQ_W             = 2 * RADIUS_W + 1;
   localparam int ROOT_W           = RADIUS_W + 1;
   localparam int RAD_W            = 2 * ROOT_W;
   localparam int REM_W            = ROOT_W + 3;
   localparam int QUO_W            = NORMAL_FRAC_BITS + 1;
   localparam int DREM_W           = ROOT_W + 1;
   localparam int PEN_W            = DIN_W + 2;

   localparam logic [NORMAL_W-1:0] NORMAL_ONE = NORMAL_W'(64'd1 << NORMAL_FRAC_BITS);

   typedef logic signed [COORD_WIDTH-1:0] coord_type;

   typedef struct packed {
      coord_type box_pos_x;
      coord_type box_pos_y;
      coord_type box_min_x;
      coord_type box_max_x;
      coord_type box_min_y;
      coord_type box_max_y;
      coord_type circle_pos_x;
      coord_type circle_pos_y;
      logic [RADIUS_W-1:0] circle_radius;
   } req_type;

   typedef struct packed {
      logic                hit;
      logic                in_box;
      logic                xaxis;
      logic                uneg;
      logic [DIN_W-1:0]    din;
      logic [RADIUS_W-1:0] ax;
      logic [RADIUS_W-1:0] ay;
      logic                negx;
      logic                negy;
      logic [RADIUS_W-1:0] radius;
   } ctx_type;

   typedef struct packed {
      logic                       hit;
      logic signed [NORMAL_W-1:0] normal_x;
      logic signed [NORMAL_W-1:0] normal_y;
      coord_type                  penetration;
   } rsp_type;

endpackage

// ----- sv/acc_req_if.sv -----
// Request channel: one box/circle pair per word, valid/ready handshake.
// Depends on acc_pkg for field widths.
interface acc_req_if;
   logic valid;
   logic ready;
   logic signed [acc_pkg::COORD_WIDTH-1:0] box_pos_x;
   logic signed [acc_pkg::COORD_WIDTH-1:0] box_pos_y;
   logic signed [acc_pkg::COORD_WIDTH-1:0] box_min_x;
   logic signed [acc_pkg::COORD_WIDTH-1:0] box_max_x;
   logic signed [acc_pkg::COORD_WIDTH-1:0] box_min_y;
   logic signed [acc_pkg::COORD_WIDTH-1:0] box_max_y;
   logic signed [acc_pkg::COORD_WIDTH-1:0] circle_pos_x;
   logic signed [acc_pkg::COORD_WIDTH-1:0] circle_pos_y;
   logic [acc_pkg::RADIUS_W-1:0]           circle_radius;

   modport source (output valid, box_pos_x, box_pos_y, box_min_x, box_max_x, box_min_y,
                   box_max_y, circle_pos_x, circle_pos_y, circle_radius, input ready);
   modport sink   (input valid, box_pos_x, box_pos_y, box_min_x, box_max_x, box_min_y,
                   box_max_y, circle_pos_x, circle_pos_y, circle_radius, output ready);
endinterface

// ----- sv/acc_rsp_if.sv -----
// Response channel: one contact result per word, valid/ready handshake.
// Depends on acc_pkg for field widths.
interface acc_rsp_if;
   logic valid;
   logic ready;
   logic hit;
   logic signed [acc_pkg::NORMAL_W-1:0]    normal_x;
   logic signed [acc_pkg::NORMAL_W-1:0]    normal_y;
   logic signed [acc_pkg::COORD_WIDTH-1:0] penetration;

   modport source (output valid, hit, normal_x, normal_y, penetration, input ready);
   modport sink   (input valid, hit, normal_x, normal_y, penetration, output ready);
endinterface

// ----- sv/acc_front.sv -----
// Geometry front end: offset, half extents, clamp, face snap, squares, hit test.
// Five register stages. Depends on acc_pkg.
module acc_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  acc_pkg::req_type              in_req,
   output logic                          out_valid,
   output acc_pkg::ctx_type              out_ctx,
   output logic [acc_pkg::SQ_W-1:0]      out_sq
);
   localparam int NW = acc_pkg::OFF_W;
   localparam int VW = acc_pkg::VEC_W;
   localparam int RW = acc_pkg::RADIUS_W;
   localparam int SW = acc_pkg::SQ_W;

   // stage 1
   logic v1_ff;
   logic signed [NW-1:0] off_x_in, off_y_in, off_x_ff, off_y_ff;
   logic signed [NW-1:0] span_x, span_y;
   acc_pkg::coord_type   ext_x_in, ext_y_in, ext_x_ff, ext_y_ff;
   logic [RW-1:0]        rad1_ff;

   // stage 2
   logic v2_ff;
   logic signed [NW-1:0] ew_x, ew_y, en_x, en_y, clamp_x, clamp_y;
   logic signed [NW-1:0] off_x2_ff, off_y2_ff, ew_x2_ff, ew_y2_ff, clamp_x2_ff, clamp_y2_ff;
   logic signed [VW-1:0] vec_x_in, vec_y_in, vec_x2_ff, vec_y2_ff;
   logic                 in_box_in, in_box2_ff;
   logic [RW-1:0]        rad2_ff;

   // stage 3
   logic v3_ff;
   logic [NW-1:0]        abs_nx, abs_ny;
   logic                 xaxis, pos;
   logic signed [NW-1:0] sel_c, sel_e, sel_n;
   logic signed [VW-1:0] vin;
   logic [VW-1:0]        ax_full, ay_full;
   logic                 far_in, far3_ff;
   acc_pkg::ctx_type     ctx3_in, ctx3_ff;

   // stage 4
   logic v4_ff;
   logic [2*RW-1:0]      sqx4_in, sqy4_in, rr4_in, sqx4_ff, sqy4_ff, rr4_ff;
   logic                 far4_ff;
   acc_pkg::ctx_type     ctx4_ff;

   // stage 5
   logic v5_ff;
   logic [SW-1:0]        sum_in, sum5_ff;
   acc_pkg::ctx_type     ctx5_in, ctx5_ff;

   always_comb begin
      off_x_in = NW'(in_req.circle_pos_x) - NW'(in_req.box_pos_x);
      off_y_in = NW'(in_req.circle_pos_y) - NW'(in_req.box_pos_y);
      span_x   = NW'(in_req.box_max_x) - NW'(in_req.box_min_x);
      span_y   = NW'(in_req.box_max_y) - NW'(in_req.box_min_y);
      ext_x_in = span_x[NW-1:1];
      ext_y_in = span_y[NW-1:1];
   end

   always_comb begin
      ew_x = NW'(ext_x_ff);
      ew_y = NW'(ext_y_ff);
      en_x = -ew_x;
      en_y = -ew_y;
      clamp_x = (off_x_ff > ew_x) ? ew_x : ((off_x_ff < en_x) ? en_x : off_x_ff);
      clamp_y = (off_y_ff > ew_y) ? ew_y : ((off_y_ff < en_y) ? en_y : off_y_ff);
      vec_x_in  = VW'(off_x_ff) - VW'(clamp_x);
      vec_y_in  = VW'(off_y_ff) - VW'(clamp_y);
      in_box_in = (clamp_x == off_x_ff) && (clamp_y == off_y_ff);
   end

   always_comb begin
      abs_nx  = off_x2_ff[NW-1] ? NW'(-off_x2_ff) : NW'(off_x2_ff);
      abs_ny  = off_y2_ff[NW-1] ? NW'(-off_y2_ff) : NW'(off_y2_ff);
      xaxis   = abs_nx > abs_ny;
      sel_c   = xaxis ? clamp_x2_ff : clamp_y2_ff;
      sel_e   = xaxis ? ew_x2_ff : ew_y2_ff;
      sel_n   = xaxis ? off_x2_ff : off_y2_ff;
      pos     = !sel_c[NW-1] && (sel_c != '0);
      vin     = VW'(sel_n) - (pos ? VW'(sel_e) : -VW'(sel_e));
      ax_full = vec_x2_ff[VW-1] ? VW'(-vec_x2_ff) : VW'(vec_x2_ff);
      ay_full = vec_y2_ff[VW-1] ? VW'(-vec_y2_ff) : VW'(vec_y2_ff);
      far_in  = (ax_full > VW'(rad2_ff)) || (ay_full > VW'(rad2_ff));
      ctx3_in.hit    = 1'b0;
      ctx3_in.in_box = in_box2_ff;
      ctx3_in.xaxis  = xaxis;
      ctx3_in.uneg   = (vin == '0) ? !pos : !vin[VW-1];
      ctx3_in.din    = vin[VW-1] ? acc_pkg::DIN_W'(-vin) : acc_pkg::DIN_W'(vin);
      ctx3_in.ax     = ax_full[RW-1:0];
      ctx3_in.ay     = ay_full[RW-1:0];
      ctx3_in.negx   = vec_x2_ff[VW-1];
      ctx3_in.negy   = vec_y2_ff[VW-1];
      ctx3_in.radius = rad2_ff;
   end

   always_comb begin
      sqx4_in = (2*RW)'(ctx3_ff.ax) * (2*RW)'(ctx3_ff.ax);
      sqy4_in = (2*RW)'(ctx3_ff.ay) * (2*RW)'(ctx3_ff.ay);
      rr4_in  = (2*RW)'(ctx3_ff.radius) * (2*RW)'(ctx3_ff.radius);
   end

   always_comb begin
      sum_in      = SW'(sqx4_ff) + SW'(sqy4_ff);
      ctx5_in     = ctx4_ff;
      ctx5_in.hit = ctx4_ff.in_box || (!far4_ff && (sum_in <= SW'(rr4_ff)));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         off_x_ff    <= off_x_in;
         off_y_ff    <= off_y_in;
         ext_x_ff    <= ext_x_in;
         ext_y_ff    <= ext_y_in;
         rad1_ff     <= in_req.circle_radius;
         off_x2_ff   <= off_x_ff;
         off_y2_ff   <= off_y_ff;
         ew_x2_ff    <= ew_x;
         ew_y2_ff    <= ew_y;
         clamp_x2_ff <= clamp_x;
         clamp_y2_ff <= clamp_y;
         vec_x2_ff   <= vec_x_in;
         vec_y2_ff   <= vec_y_in;
         in_box2_ff  <= in_box_in;
         rad2_ff     <= rad1_ff;
         ctx3_ff     <= ctx3_in;
         far3_ff     <= far_in;
         sqx4_ff     <= sqx4_in;
         sqy4_ff     <= sqy4_in;
         rr4_ff      <= rr4_in;
         ctx4_ff     <= ctx3_ff;
         far4_ff     <= far3_ff;
         sum5_ff     <= sum_in;
         ctx5_ff     <= ctx5_in;
      end
   end

   assign out_valid = v5_ff;
   assign out_ctx   = ctx5_ff;
   assign out_sq    = sum5_ff;

endmodule

// ----- sv/acc_sqrt.sv -----
// Pipelined integer square root, one root bit per register stage.
// Carries the contact context alongside. Depends on acc_pkg.
module acc_sqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  acc_pkg::ctx_type              in_ctx,
   input  logic [acc_pkg::SQ_W-1:0]      in_sq,
   output logic                          out_valid,
   output acc_pkg::ctx_type              out_ctx,
   output logic [acc_pkg::ROOT_W-1:0]    out_root
);
   localparam int N  = acc_pkg::ROOT_W;
   localparam int EW = acc_pkg::REM_W;
   localparam int AW = acc_pkg::RAD_W;

   logic             vld_ff  [N];
   acc_pkg::ctx_type ctx_ff  [N];
   acc_pkg::ctx_type ctx_in  [N];
   logic [AW-1:0]    rad_ff  [N];
   logic [AW-1:0]    rad_in  [N];
   logic [EW-1:0]    rem_ff  [N];
   logic [EW-1:0]    rem_in  [N];
   logic [N-1:0]     root_ff [N];
   logic [N-1:0]     root_in [N];
   logic             vld_in  [N];

   always_comb begin
      logic [AW-1:0] rad_p;
      logic [EW-1:0] rem_p, trial, sub;
      logic [N-1:0]  root_p;
      logic          ge;
      for (int k = 0; k < N; k++) begin
         if (k == 0) begin
            rad_p     = AW'(in_sq);
            rem_p     = '0;
            root_p    = '0;
            ctx_in[k] = in_ctx;
            vld_in[k] = in_valid;
         end else begin
            rad_p     = rad_ff[k-1];
            rem_p     = rem_ff[k-1];
            root_p    = root_ff[k-1];
            ctx_in[k] = ctx_ff[k-1];
            vld_in[k] = vld_ff[k-1];
         end
         trial = {rem_p[EW-3:0], rad_p[AW-1 -: 2]};
         sub   = EW'({root_p, 2'b01});
         ge    = trial >= sub;
         rem_in[k]  = ge ? trial - sub : trial;
         root_in[k] = {root_p[N-2:0], ge};
         rad_in[k]  = {rad_p[AW-3:0], 2'b00};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < N; k++) vld_ff[k] <= 1'b0;
      end else if (en) begin
         for (int k = 0; k < N; k++) vld_ff[k] <= vld_in[k];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < N; k++) begin
            ctx_ff[k]  <= ctx_in[k];
            rad_ff[k]  <= rad_in[k];
            rem_ff[k]  <= rem_in[k];
            root_ff[k] <= root_in[k];
         end
      end
   end

   assign out_valid = vld_ff[N-1];
   assign out_ctx   = ctx_ff[N-1];
   assign out_root  = root_ff[N-1];

endmodule

// ----- sv/acc_norm.sv -----
// Normal and penetration: two-lane pipelined divider, one quotient bit per stage,
// then sign, face-snap select and saturation. Depends on acc_pkg.
module acc_norm (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  acc_pkg::ctx_type              in_ctx,
   input  logic [acc_pkg::ROOT_W-1:0]    in_root,
   output logic                          out_valid,
   output acc_pkg::rsp_type              out_rsp
);
   localparam int N  = acc_pkg::QUO_W;
   localparam int DW = acc_pkg::ROOT_W;
   localparam int RW = acc_pkg::DREM_W;
   localparam int PW = acc_pkg::PEN_W;
   localparam int OW = acc_pkg::NORMAL_W;
   localparam logic signed [PW-1:0] PEN_MAX =
      PW'((64'd1 << (acc_pkg::COORD_WIDTH - 1)) - 64'd1);
   localparam logic signed [PW-1:0] PEN_MIN = -PEN_MAX - PW'(1);

   logic             vld_ff [N];
   logic             vld_in [N];
   acc_pkg::ctx_type ctx_ff [N];
   acc_pkg::ctx_type ctx_in [N];
   logic [DW-1:0]    div_ff [N];
   logic [DW-1:0]    div_in [N];
   logic [RW-1:0]    rx_ff  [N];
   logic [RW-1:0]    rx_in  [N];
   logic [RW-1:0]    ry_ff  [N];
   logic [RW-1:0]    ry_in  [N];
   logic [N-1:0]     qx_ff  [N];
   logic [N-1:0]     qx_in  [N];
   logic [N-1:0]     qy_ff  [N];
   logic [N-1:0]     qy_in  [N];

   logic                  vout_ff;
   acc_pkg::rsp_type      rsp_in, rsp_ff;
   acc_pkg::ctx_type      cl;
   logic [acc_pkg::DIN_W-1:0] d_sel;
   logic signed [PW-1:0]  pen;
   logic [OW-1:0]         fx, fy, ux;

   always_comb begin
      logic [RW-1:0] ax_p, ay_p, tx, ty;
      logic [N-1:0]  qx_p, qy_p;
      logic [DW-1:0] d_p;
      logic          gx, gy;
      for (int k = 0; k < N; k++) begin
         if (k == 0) begin
            d_p       = in_root;
            ax_p      = '0;
            ay_p      = '0;
            tx        = RW'(in_ctx.ax);
            ty        = RW'(in_ctx.ay);
            qx_p      = '0;
            qy_p      = '0;
            ctx_in[k] = in_ctx;
            vld_in[k] = in_valid;
         end else begin
            d_p       = div_ff[k-1];
            ax_p      = rx_ff[k-1];
            ay_p      = ry_ff[k-1];
            tx        = {ax_p[RW-2:0], 1'b0};
            ty        = {ay_p[RW-2:0], 1'b0};
            qx_p      = qx_ff[k-1];
            qy_p      = qy_ff[k-1];
            ctx_in[k] = ctx_ff[k-1];
            vld_in[k] = vld_ff[k-1];
         end
         gx = tx >= RW'(d_p);
         gy = ty >= RW'(d_p);
         rx_in[k]  = gx ? tx - RW'(d_p) : tx;
         ry_in[k]  = gy ? ty - RW'(d_p) : ty;
         qx_in[k]  = {qx_p[N-2:0], gx};
         qy_in[k]  = {qy_p[N-2:0], gy};
         div_in[k] = d_p;
      end
   end

   always_comb begin
      cl    = ctx_ff[N-1];
      d_sel = cl.in_box ? cl.din : acc_pkg::DIN_W'(div_ff[N-1]);
      pen   = PW'(cl.radius) - PW'(d_sel);
      fx    = OW'(qx_ff[N-1]);
      fy    = OW'(qy_ff[N-1]);
      ux    = cl.uneg ? -acc_pkg::NORMAL_ONE : acc_pkg::NORMAL_ONE;
      rsp_in = '0;
      if (cl.hit) begin
         rsp_in.hit = 1'b1;
         if (pen > PEN_MAX) begin
            rsp_in.penetration = PEN_MAX[acc_pkg::COORD_WIDTH-1:0];
         end else if (pen < PEN_MIN) begin
            rsp_in.penetration = PEN_MIN[acc_pkg::COORD_WIDTH-1:0];
         end else begin
            rsp_in.penetration = pen[acc_pkg::COORD_WIDTH-1:0];
         end
         if (cl.in_box) begin
            rsp_in.normal_x = cl.xaxis ? ux : '0;
            rsp_in.normal_y = cl.xaxis ? '0 : ux;
         end else begin
            rsp_in.normal_x = cl.negx ? -fx : fx;
            rsp_in.normal_y = cl.negy ? -fy : fy;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < N; k++) vld_ff[k] <= 1'b0;
         vout_ff <= 1'b0;
      end else if (en) begin
         for (int k = 0; k < N; k++) vld_ff[k] <= vld_in[k];
         vout_ff <= vld_ff[N-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < N; k++) begin
            ctx_ff[k] <= ctx_in[k];
            div_ff[k] <= div_in[k];
            rx_ff[k]  <= rx_in[k];
            ry_ff[k]  <= ry_in[k];
            qx_ff[k]  <= qx_in[k];
            qy_ff[k]  <= qy_in[k];
         end
         rsp_ff <= rsp_in;
      end
   end

   assign out_valid = vout_ff;
   assign out_rsp   = rsp_ff;

endmodule

// ----- sv/aabb_circle_collision.sv -----
// Box versus circle contact test, top level: front end, root, divider, output skid.
// Depends on acc_pkg, acc_req_if, acc_rsp_if, acc_front, acc_sqrt, acc_norm.
//
// Usage: req_ch carries one pair per word (box position and corners and circle
// centre in signed Q16.16, radius unsigned); rsp_ch returns one word per pair,
// in order: hit, Q1.14 normal from box to circle and saturated penetration. No
// hit gives zero normal and zero penetration.
// Stages: 5 geometry stages, 32 square-root stages at one root bit each, 15 divider
// stages at one normal bit each, one result stage and one output register.
// Throughput: one pair per cycle unless the spare is full; the whole datapath
// advances together on a single enable and bubbles travel with their valid bits.
// Stall: the output register is backed by a spare register. When rsp_ch stalls,
// the word in flight lands in the spare and req_ch.ready drops the next cycle
// (a registered signal); nothing is lost or repeated.
// Reset: synchronous, active high; clears all valid bits, no pending words.
module aabb_circle_collision (
   input  logic        clock,
   input  logic        reset,
   acc_req_if.sink     req_ch,
   acc_rsp_if.source   rsp_ch
);
   logic               en;
   acc_pkg::req_type   req;
   logic               fr_valid, sq_valid, nm_valid;
   acc_pkg::ctx_type   fr_ctx, sq_ctx;
   logic [acc_pkg::SQ_W-1:0]   fr_sq;
   logic [acc_pkg::ROOT_W-1:0] sq_root;
   acc_pkg::rsp_type   nm_rsp;

   logic               out_valid_ff, out_valid_in, sp_valid_ff, sp_valid_in;
   acc_pkg::rsp_type   out_data_ff, out_data_in, sp_data_ff, sp_data_in;
   logic               push, take;

   always_comb begin
      req.box_pos_x     = req_ch.box_pos_x;
      req.box_pos_y     = req_ch.box_pos_y;
      req.box_min_x     = req_ch.box_min_x;
      req.box_max_x     = req_ch.box_max_x;
      req.box_min_y     = req_ch.box_min_y;
      req.box_max_y     = req_ch.box_max_y;
      req.circle_pos_x  = req_ch.circle_pos_x;
      req.circle_pos_y  = req_ch.circle_pos_y;
      req.circle_radius = req_ch.circle_radius;
   end

   assign en           = !sp_valid_ff;
   assign req_ch.ready = en;

   acc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_ch.valid),
      .in_req   (req),
      .out_valid(fr_valid),
      .out_ctx  (fr_ctx),
      .out_sq   (fr_sq)
   );

   acc_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (fr_valid),
      .in_ctx   (fr_ctx),
      .in_sq    (fr_sq),
      .out_valid(sq_valid),
      .out_ctx  (sq_ctx),
      .out_root (sq_root)
   );

   acc_norm u_norm (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (sq_valid),
      .in_ctx   (sq_ctx),
      .in_root  (sq_root),
      .out_valid(nm_valid),
      .out_rsp  (nm_rsp)
   );

   assign push = en && nm_valid;
   assign take = out_valid_ff && rsp_ch.ready;

   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      sp_valid_in  = sp_valid_ff;
      sp_data_in   = sp_data_ff;
      if (sp_valid_ff) begin
         if (take) begin
            out_data_in = sp_data_ff;
            sp_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || take) begin
            out_valid_in = 1'b1;
            out_data_in  = nm_rsp;
         end else begin
            sp_valid_in = 1'b1;
            sp_data_in  = nm_rsp;
         end
      end else if (take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         sp_valid_ff  <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         sp_valid_ff  <= sp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff <= out_data_in;
      sp_data_ff  <= sp_data_in;
   end

   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.hit         = out_data_ff.hit;
   assign rsp_ch.normal_x    = out_data_ff.normal_x;
   assign rsp_ch.normal_y    = out_data_ff.normal_y;
   assign rsp_ch.penetration = out_data_ff.penetration;

   a_spare_needs_out: assert property (@(posedge clock) disable iff (reset)
      sp_valid_ff |-> out_valid_ff)
      else $error("spare word held with empty output register");

   a_spare_holds: assert property (@(posedge clock) disable iff (reset)
      sp_valid_ff && !rsp_ch.ready |=> sp_valid_ff && $stable(sp_data_ff))
      else $error("spare word lost during stall");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_data_ff.hit |->
         out_data_ff.normal_x == '0 && out_data_ff.normal_y == '0 &&
         out_data_ff.penetration == '0)
      else $error("miss word carries nonzero fields");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      sp_valid_ff |-> !push)
      else $error("pipeline advanced while spare register full");

endmodule
